// File: hw/rtl/rlpe_pkg.sv
// Shared types and constants for the relocating loader patch engine.
// Used by the register block, controller, datapath and top level; no dependencies.
`timescale 1ns / 1ps

package rlpe_pkg;

    // Default parameter values.
    localparam int ADDR_BITS_DEF   = 20;
    localparam int MAX_NIBBLES_DEF = 8;

    // Fixed field widths.
    localparam int OFFSET_W = 20;
    localparam int BASE_W   = 20;
    localparam int SYM_W    = 24;
    localparam int FIELD_W  = 32;
    localparam int NIB_W    = 4;
    localparam int CNT_W    = 2;    // byte index within a field of up to four bytes
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Request codes.
    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_MODIFY = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    // Register indexes.
    localparam logic REG_SECTION_BASE = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_TEXT,
        ST_RD,
        ST_ACC,
        ST_CALC,
        ST_WR,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;        // capture a new item and clear the results
        logic issue_rd;     // read the field byte at the current index
        logic gather;       // fold the returned byte into the accumulator
        logic calc;         // apply the symbol value and rewind the index
        logic write_text;   // store the text byte
        logic write_field;  // store the field byte at the current index
        logic step;         // advance the byte index
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_load;
        logic is_read;
        logic is_modify;    // modify with a non-empty field
        logic last;         // current index is the last byte of the field
    } stat_t;

endpackage

// File: hw/rtl/relocating_loader_patch_engine_core.sv
// Top level of the relocating loader patch engine.
// Depends on rlpe_pkg, rlpe_regs, rlpe_ctrl and rlpe_datapath.
`timescale 1ns / 1ps

// An item is taken when start is high while busy is low. Each item gives one
// result beat: done is high for a single cycle with read_byte and patched_field
// valid, and the receiver cannot stall it, so it must take the beat in that
// cycle. Everything goes through one single-port byte memory with registered
// read data, and the controller handles one item at a time. A text load writes
// its byte, a read fetches one byte, and a modify of n bytes (n = 1..4) gathers
// the field with a read and an accumulate step per byte, applies the symbol
// value and writes the field back byte by byte. A modify with an empty field or
// an unknown request touches no memory. section_base should only be written while
// busy is low. Memory contents are undefined until written.

module relocating_loader_patch_engine_core
    import rlpe_pkg::*;
#(
    parameter int ADDR_BITS   = ADDR_BITS_DEF,
    parameter int MAX_NIBBLES = MAX_NIBBLES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          req_type,
    input  logic [OFFSET_W-1:0] address_offset,
    input  logic [7:0]          data_byte,
    input  logic [NIB_W-1:0]    field_nibbles,
    input  logic                subtract_flag,
    input  logic [SYM_W-1:0]    symbol_value,
    output logic                done,
    output logic [7:0]          read_byte,
    output logic [FIELD_W-1:0]  patched_field
);

    logic [BASE_W-1:0] section_base;
    cmd_t              cmd;
    stat_t             stat;

    // Configuration registers.
    rlpe_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .section_base (section_base)
    );

    // Sequencing.
    rlpe_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Memory and arithmetic.
    rlpe_datapath #(
        .ADDR_BITS   (ADDR_BITS),
        .MAX_NIBBLES (MAX_NIBBLES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .section_base   (section_base),
        .req_type       (req_type),
        .address_offset (address_offset),
        .data_byte      (data_byte),
        .field_nibbles  (field_nibbles),
        .subtract_flag  (subtract_flag),
        .symbol_value   (symbol_value),
        .read_byte      (read_byte),
        .patched_field  (patched_field)
    );

endmodule

// File: hw/rtl/rlpe_regs.sv
// APB-style configuration register block holding the section base.
// Depends on rlpe_pkg.
`timescale 1ns / 1ps

module rlpe_regs
    import rlpe_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    output logic [BASE_W-1:0]   section_base
);

    logic [BASE_W-1:0] base_reg;
    logic [BASE_W-1:0] base_next;
    logic              reg_index;
    logic              wr_en;

    // Registers sit on 32-bit word boundaries.
    assign reg_index = paddr[PADDR_W-1];
    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready;

    // Write decode.
    always_comb
    begin
        base_next = base_reg;
        if (wr_en && (reg_index == REG_SECTION_BASE))
        begin
            base_next = pwdata[BASE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else
        begin
            base_reg <= base_next;
        end
    end

    // Read decode.
    always_comb
    begin
        unique case (reg_index)
            REG_SECTION_BASE: prdata = PDATA_W'(base_reg);
            default:          prdata = '0;
        endcase
    end

    assign section_base = base_reg;

endmodule

// File: hw/rtl/rlpe_ctrl.sv
// Controller state machine that sequences text loads, reads and field patches.
// Depends on rlpe_pkg; talks to rlpe_datapath through cmd_t and stat_t.
`timescale 1ns / 1ps

module rlpe_ctrl
    import rlpe_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  busy,
    output logic  done
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (stat.is_load)
                begin
                    state_next = ST_TEXT;
                end
                else if (stat.is_read || stat.is_modify)
                begin
                    state_next = ST_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_TEXT: state_next = ST_DONE;
            ST_RD:   state_next = ST_ACC;
            ST_ACC:
            begin
                if (stat.is_read)
                begin
                    state_next = ST_DONE;
                end
                else if (stat.last)
                begin
                    state_next = ST_CALC;
                end
                else
                begin
                    state_next = ST_RD;
                end
            end
            ST_CALC: state_next = ST_WR;
            ST_WR:
            begin
                if (stat.last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy      = 1'b0;
                cmd.latch = start;
            end
            ST_DISPATCH: ;
            ST_TEXT:     cmd.write_text = 1'b1;
            ST_RD:       cmd.issue_rd   = 1'b1;
            ST_ACC:
            begin
                cmd.gather = 1'b1;
                cmd.step   = !stat.is_read && !stat.last;
            end
            ST_CALC:     cmd.calc = 1'b1;
            ST_WR:
            begin
                cmd.write_field = 1'b1;
                cmd.step        = !stat.last;
            end
            ST_DONE:     done = 1'b1;
            default:     busy = 1'b1;
        endcase
    end

endmodule

// File: hw/rtl/rlpe_datapath.sv
// Datapath: byte memory, item registers, field accumulator and add/subtract unit.
// Depends on rlpe_pkg; driven by rlpe_ctrl through cmd_t.
`timescale 1ns / 1ps

module rlpe_datapath
    import rlpe_pkg::*;
#(
    parameter int ADDR_BITS   = ADDR_BITS_DEF,
    parameter int MAX_NIBBLES = MAX_NIBBLES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output stat_t               stat,
    input  logic [BASE_W-1:0]   section_base,
    input  logic [1:0]          req_type,
    input  logic [OFFSET_W-1:0] address_offset,
    input  logic [7:0]          data_byte,
    input  logic [NIB_W-1:0]    field_nibbles,
    input  logic                subtract_flag,
    input  logic [SYM_W-1:0]    symbol_value,
    output logic [7:0]          read_byte,
    output logic [FIELD_W-1:0]  patched_field
);

    localparam int SUM_W = (ADDR_BITS > OFFSET_W + 1) ? ADDR_BITS : OFFSET_W + 1;

    logic [7:0]           mem [0:(2**ADDR_BITS)-1];
    logic [7:0]           rdata_reg;

    logic [1:0]           req_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [7:0]           data_reg;
    logic [NIB_W-1:0]     nib_reg;
    logic [CNT_W-1:0]     last_idx_reg;
    logic                 sub_reg;
    logic [SYM_W-1:0]     sym_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [FIELD_W-1:0]   acc_reg;
    logic [7:0]           first_reg;
    logic [7:0]           read_byte_reg;
    logic [FIELD_W-1:0]   patched_reg;

    logic [SUM_W-1:0]     addr_sum;
    logic [NIB_W-1:0]     nib_clamped;
    logic [NIB_W-1:0]     nib_m1;
    logic [ADDR_BITS-1:0] mem_addr;
    logic                 mem_we;
    logic [7:0]           mem_wdata;
    logic [7:0]           gather_byte;
    logic [CNT_W-1:0]     out_idx;
    logic [7:0]           field_byte;
    logic [FIELD_W-1:0]   field_mask;
    logic [FIELD_W-1:0]   field_sum;

    // Start address, wrapped to the memory size.
    assign addr_sum    = SUM_W'(section_base) + SUM_W'(address_offset);
    assign nib_clamped = (field_nibbles > NIB_W'(MAX_NIBBLES)) ? NIB_W'(MAX_NIBBLES)
                                                               : field_nibbles;
    assign nib_m1      = nib_clamped - NIB_W'(1);

    // Item registers and control counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg <= REQ_LOAD;
            nib_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (cmd.latch)
            begin
                req_reg <= req_type;
                nib_reg <= nib_clamped;
            end
            if (cmd.latch || cmd.calc)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.step)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    // Payload registers of the accepted beat.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            addr_reg     <= addr_sum[ADDR_BITS-1:0];
            data_reg     <= data_byte;
            last_idx_reg <= nib_m1[CNT_W:1];
            sub_reg      <= subtract_flag;
            sym_reg      <= symbol_value;
        end
    end

    // Status towards the controller.
    assign stat.is_load   = (req_reg == REQ_LOAD);
    assign stat.is_read   = (req_reg == REQ_READ);
    assign stat.is_modify = (req_reg == REQ_MODIFY) && (nib_reg != '0);
    assign stat.last      = (cnt_reg == last_idx_reg);

    // Single-port byte memory with registered read data.
    assign mem_addr  = addr_reg + ADDR_BITS'(cnt_reg);
    assign mem_we    = cmd.write_text || cmd.write_field;
    assign out_idx   = last_idx_reg - cnt_reg;
    assign field_byte = 8'(patched_reg >> {out_idx, 3'b000});

    always_comb
    begin
        if (cmd.write_text)
        begin
            mem_wdata = data_reg;
        end
        else if ((cnt_reg == '0) && nib_reg[0])
        begin
            // Odd field: the upper nibble of the first byte is kept.
            mem_wdata = {first_reg[7:4], field_byte[3:0]};
        end
        else
        begin
            mem_wdata = field_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (cmd.issue_rd)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    // Odd field: only the low nibble of the first byte is part of the value.
    assign gather_byte = ((cnt_reg == '0) && nib_reg[0]) ? {4'h0, rdata_reg[3:0]}
                                                         : rdata_reg;

    // Field arithmetic, truncated to the field width.
    assign field_mask = ~({FIELD_W{1'b1}} << {nib_reg, 2'b00});
    assign field_sum  = sub_reg ? (acc_reg - FIELD_W'(sym_reg))
                                : (acc_reg + FIELD_W'(sym_reg));

    // Accumulator and result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            acc_reg       <= '0;
            read_byte_reg <= '0;
            patched_reg   <= '0;
        end
        else
        begin
            if (cmd.gather)
            begin
                acc_reg <= {acc_reg[FIELD_W-9:0], gather_byte};
                if (cnt_reg == '0)
                begin
                    first_reg <= rdata_reg;
                end
                if (req_reg == REQ_READ)
                begin
                    read_byte_reg <= rdata_reg;
                end
            end
            if (cmd.calc)
            begin
                patched_reg <= field_sum & field_mask;
            end
        end
    end

    assign read_byte     = read_byte_reg;
    assign patched_field = patched_reg;

endmodule

// File: tb/rlpe_patch_checker.sv
// Scoreboard for the relocating loader patch engine: tracks the section base and a
// shadow copy of the byte memory, predicts every result beat and compares it.
// Depends on rlpe_pkg only.
`timescale 1ns / 1ps

module rlpe_patch_checker
    import rlpe_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    input  logic                pready,
    input  logic                start,
    input  logic                busy,
    input  logic [1:0]          req_type,
    input  logic [OFFSET_W-1:0] address_offset,
    input  logic [7:0]          data_byte,
    input  logic [NIB_W-1:0]    field_nibbles,
    input  logic                subtract_flag,
    input  logic [SYM_W-1:0]    symbol_value,
    input  logic                done,
    input  logic [7:0]          read_byte,
    input  logic [FIELD_W-1:0]  patched_field,
    output int                  fail_count,
    output int                  pending
);

    localparam logic [PADDR_W-1:0] BASE_ADDR = {REG_SECTION_BASE, 2'b00};

    typedef struct packed {
        logic [7:0]         rbyte;
        logic [FIELD_W-1:0] field;
    } patch_beat_t;

    // Shadow of the engine's byte memory and of the section base register.
    logic [7:0]              mem_image [logic [ADDR_BITS_DEF-1:0]];
    logic [BASE_W-1:0]       base_shadow;
    patch_beat_t             due_results [$];

    function automatic logic [7:0] image_byte(input logic [ADDR_BITS_DEF-1:0] a);
        return mem_image.exists(a) ? mem_image[a] : 8'h00;
    endfunction

    // Applies one item to the shadow memory and returns the beat it should produce.
    function automatic patch_beat_t apply_item(
        input logic [1:0]          kind,
        input logic [OFFSET_W-1:0] off,
        input logic [7:0]          dbyte,
        input logic [NIB_W-1:0]    nib_in,
        input logic                sub,
        input logic [SYM_W-1:0]    sym
    );
        patch_beat_t              beat;
        logic [ADDR_BITS_DEF-1:0] at;
        logic [ADDR_BITS_DEF-1:0] a;
        int unsigned              nib;
        int unsigned              nbytes;
        int unsigned              i;
        logic [63:0]              acc;
        logic [63:0]              mask;
        logic [7:0]               b;
        logic [7:0]               old;
        beat = '0;
        at = base_shadow + off;
        case (kind)
            REQ_LOAD:
            begin
                mem_image[at] = dbyte;
            end
            REQ_READ:
            begin
                beat.rbyte = image_byte(at);
            end
            REQ_MODIFY:
            begin
                if (nib_in != 0)
                begin
                    nib = (nib_in > MAX_NIBBLES_DEF) ? MAX_NIBBLES_DEF : nib_in;
                    nbytes = (nib + 1) / 2;
                    mask = (64'd1 << (4 * nib)) - 64'd1;
                    // Gather big-endian; an odd count drops the top nibble of the first byte.
                    acc = '0;
                    for (i = 0; i < nbytes; i++)
                    begin
                        a = at + ADDR_BITS_DEF'(i);
                        b = image_byte(a);
                        if (i == 0 && nib[0])
                            b[7:4] = 4'h0;
                        acc = (acc << 8) | b;
                    end
                    acc = sub ? acc - sym : acc + sym;
                    acc &= mask;
                    // Write back; the upper nibble of an odd first byte is kept.
                    for (i = 0; i < nbytes; i++)
                    begin
                        a = at + ADDR_BITS_DEF'(i);
                        b = acc[8 * (nbytes - 1 - i) +: 8];
                        if (i == 0 && nib[0])
                        begin
                            old = image_byte(a);
                            mem_image[a] = {old[7:4], b[3:0]};
                        end
                        else
                        begin
                            mem_image[a] = b;
                        end
                    end
                    beat.field = acc[FIELD_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
        return beat;
    endfunction

    // Compare result beats, predict accepted items and follow register writes.
    always @(posedge clk or negedge rst_n)
    begin
        patch_beat_t want;
        if (!rst_n)
        begin
            base_shadow = '0;
            mem_image.delete();
            due_results.delete();
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result beat with no item outstanding");
                    fail_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (read_byte !== want.rbyte)
                    begin
                        $error("read_byte: expected %0h, got %0h", want.rbyte, read_byte);
                        fail_count++;
                    end
                    if (patched_field !== want.field)
                    begin
                        $error("patched_field: expected %0h, got %0h", want.field,
                               patched_field);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                due_results.push_back(apply_item(req_type, address_offset, data_byte,
                                                 field_nibbles, subtract_flag, symbol_value));
            if (psel && penable && pwrite && pready && paddr == BASE_ADDR)
                base_shadow = pwdata[BASE_W-1:0];
            pending <= due_results.size();
        end
    end

endmodule

// File: tb/relocating_loader_patch_engine_core_tb.sv
// Testbench top for the relocating loader patch engine: clock, reset, APB set-up of
// the section base and command stimulus; checking is left to rlpe_patch_checker.
// Depends on rlpe_pkg, rlpe_patch_checker and relocating_loader_patch_engine_core.
`timescale 1ns / 1ps

module relocating_loader_patch_engine_core_tb;
    import rlpe_pkg::*;

    localparam int                 CYCLE_LIMIT = 250000;
    localparam logic [PADDR_W-1:0] BASE_ADDR   = {REG_SECTION_BASE, 2'b00};
    // Request code that the engine does not recognise.
    localparam logic [1:0]         REQ_UNKNOWN = 2'd3;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                start;
    logic                busy;
    logic [1:0]          req_type;
    logic [OFFSET_W-1:0] address_offset;
    logic [7:0]          data_byte;
    logic [NIB_W-1:0]    field_nibbles;
    logic                subtract_flag;
    logic [SYM_W-1:0]    symbol_value;
    logic                done;
    logic [7:0]          read_byte;
    logic [FIELD_W-1:0]  patched_field;
    int                  fail_count;
    int                  pending;

    // Stimulus bookkeeping: current base and every absolute address loaded so far.
    logic [BASE_W-1:0]        base_now;
    bit                       loaded [logic [ADDR_BITS_DEF-1:0]];
    logic [ADDR_BITS_DEF-1:0] loaded_list [$];
    bit                       gaps_on;
    int                       quiet_left;

    relocating_loader_patch_engine_core u_top (.*);

    rlpe_patch_checker u_check (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // True when every byte that a modify of this width would read has been loaded.
    function automatic bit field_ready(input logic [ADDR_BITS_DEF-1:0] at, input int nib);
        int                       n;
        int                       i;
        logic [ADDR_BITS_DEF-1:0] a;
        n = (nib > MAX_NIBBLES_DEF) ? MAX_NIBBLES_DEF : nib;
        for (i = 0; i < (n + 1) / 2; i++)
        begin
            a = at + ADDR_BITS_DEF'(i);
            if (!loaded.exists(a))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Writes the section base through a setup and an access cycle.
    task automatic write_base(input logic [BASE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BASE_ADDR;
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        base_now = value;
    endtask

    // Drops start and waits until the engine is idle with nothing outstanding.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Issues one command beat for an absolute address, with an optional idle burst first.
    task automatic send_item(
        input logic [1:0]               kind,
        input logic [ADDR_BITS_DEF-1:0] at,
        input logic [7:0]               dbyte,
        input logic [NIB_W-1:0]         nib,
        input logic                     sub,
        input logic [SYM_W-1:0]         sym
    );
        int gap;
        gap = 0;
        if (gaps_on)
        begin
            if (quiet_left > 0)
                quiet_left--;
            else if ($urandom_range(0, 29) == 0)
                quiet_left = $urandom_range(10, 40);
            else if ($urandom_range(0, 2) == 0)
                gap = $urandom_range(1, 13);
        end
        if (gap > 0)
        begin
            // Idle with junk on the payload; the engine must ignore it.
            start          <= 1'b0;
            req_type       <= 2'($urandom);
            address_offset <= OFFSET_W'($urandom);
            data_byte      <= 8'($urandom);
            field_nibbles  <= NIB_W'($urandom);
            subtract_flag  <= 1'($urandom);
            symbol_value   <= SYM_W'($urandom);
            repeat (gap) @(posedge clk);
        end
        start          <= 1'b1;
        req_type       <= kind;
        address_offset <= at - base_now;
        data_byte      <= dbyte;
        field_nibbles  <= nib;
        subtract_flag  <= sub;
        symbol_value   <= sym;
        if (kind == REQ_LOAD && !loaded.exists(at))
        begin
            loaded[at] = 1'b1;
            loaded_list.push_back(at);
        end
        do
            @(posedge clk);
        while (busy);
    endtask

    // Random traffic, mostly load-then-patch records with some stray commands between.
    task automatic random_run(input int want);
        int                       issued;
        int                       rec_len;
        int                       ops;
        int                       j;
        int                       k;
        int                       nib;
        logic [ADDR_BITS_DEF-1:0] at;
        logic [ADDR_BITS_DEF-1:0] spot;
        issued = 0;
        while (issued < want)
        begin
            if ($urandom_range(0, 99) < 70)
            begin
                case ($urandom_range(0, 7))
                    0: at = 20'hFFFFF - 20'($urandom_range(0, 3));
                    1: at = 20'($urandom_range(0, 3));
                    default: at = 20'($urandom);
                endcase
                rec_len = $urandom_range(1, 5);
                for (j = 0; j < rec_len; j++)
                    send_item(REQ_LOAD, at + ADDR_BITS_DEF'(j), 8'($urandom),
                              NIB_W'($urandom), 1'($urandom), SYM_W'($urandom));
                ops = $urandom_range(1, 4);
                for (k = 0; k < ops; k++)
                begin
                    j = $urandom_range(0, rec_len - 1);
                    spot = at + ADDR_BITS_DEF'(j);
                    if ($urandom_range(0, 2) == 0)
                    begin
                        send_item(REQ_READ, spot, 8'($urandom), NIB_W'($urandom),
                                  1'($urandom), SYM_W'($urandom));
                    end
                    else
                    begin
                        // Oversized widths only where four bytes are loaded.
                        if (rec_len - j >= 4 && $urandom_range(0, 3) == 0)
                            nib = $urandom_range(9, 15);
                        else
                            nib = $urandom_range(1, (2 * (rec_len - j) > MAX_NIBBLES_DEF) ?
                                                    MAX_NIBBLES_DEF : 2 * (rec_len - j));
                        send_item(REQ_MODIFY, spot, 8'($urandom), NIB_W'(nib),
                                  1'($urandom), SYM_W'($urandom));
                    end
                end
                issued += rec_len + ops;
            end
            else
            begin
                spot = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
                case ($urandom_range(0, 4))
                    0:
                    begin
                        send_item(REQ_UNKNOWN, 20'($urandom), 8'($urandom),
                                  NIB_W'($urandom), 1'($urandom), SYM_W'($urandom));
                    end
                    1:
                    begin
                        send_item(REQ_MODIFY, 20'($urandom), 8'($urandom), '0,
                                  1'($urandom), SYM_W'($urandom));
                    end
                    2:
                    begin
                        send_item(REQ_READ, spot, 8'($urandom), NIB_W'($urandom),
                                  1'($urandom), SYM_W'($urandom));
                        issued++;
                    end
                    3:
                    begin
                        nib = $urandom_range(1, 15);
                        if (field_ready(spot, nib))
                            send_item(REQ_MODIFY, spot, 8'($urandom), NIB_W'(nib),
                                      1'($urandom), SYM_W'($urandom));
                        else
                            send_item(REQ_READ, spot, 8'($urandom), NIB_W'(nib),
                                      1'($urandom), SYM_W'($urandom));
                        issued++;
                    end
                    default:
                    begin
                        send_item(REQ_LOAD, 20'($urandom), 8'($urandom), NIB_W'($urandom),
                                  1'($urandom), SYM_W'($urandom));
                        issued++;
                    end
                endcase
            end
        end
    endtask

    // Cycle counter guarding against a hung engine.
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        rst_n          <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        start          <= 1'b0;
        req_type       <= '0;
        address_offset <= '0;
        data_byte      <= '0;
        field_nibbles  <= '0;
        subtract_flag  <= 1'b0;
        symbol_value   <= '0;
        base_now       = '0;
        gaps_on        = 1'b1;
        quiet_left     = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: byte extremes, wrap at the top of memory, every field width.
        write_base(20'h00000);
        send_item(REQ_LOAD, 20'hFFFFF, 8'hFF, '0, 1'b0, '0);
        send_item(REQ_LOAD, 20'h00000, 8'h00, '0, 1'b0, '0);
        send_item(REQ_LOAD, 20'h00001, 8'hA5, '0, 1'b0, '0);
        send_item(REQ_LOAD, 20'h00002, 8'h5A, '0, 1'b0, '0);
        send_item(REQ_LOAD, 20'h00003, 8'h80, '0, 1'b0, '0);
        send_item(REQ_READ, 20'hFFFFF, 8'h00, '0, 1'b0, '0);
        send_item(REQ_MODIFY, 20'hFFFFF, 8'h00, 4'd8, 1'b0, 24'hFFFFFF);
        send_item(REQ_MODIFY, 20'hFFFFF, 8'h00, 4'd15, 1'b1, 24'hFFFFFF);
        send_item(REQ_MODIFY, 20'h00000, 8'h00, 4'd1, 1'b1, 24'h000001);
        send_item(REQ_MODIFY, 20'h00000, 8'h00, 4'd3, 1'b0, 24'hFFFFFF);
        send_item(REQ_MODIFY, 20'h00001, 8'h00, 4'd2, 1'b0, 24'h000001);
        send_item(REQ_MODIFY, 20'h00000, 8'h00, 4'd5, 1'b1, 24'h123456);
        send_item(REQ_MODIFY, 20'h00000, 8'h00, 4'd7, 1'b0, 24'hABCDEF);
        send_item(REQ_MODIFY, 20'h00000, 8'h00, 4'd4, 1'b1, 24'h000000);
        send_item(REQ_MODIFY, 20'h00000, 8'h00, 4'd6, 1'b0, 24'h800000);
        // An empty field and an unknown request touch nothing, even unloaded bytes.
        send_item(REQ_MODIFY, 20'h40000, 8'hFF, 4'd0, 1'b1, 24'hFFFFFF);
        send_item(REQ_UNKNOWN, 20'h7FFFF, 8'hFF, 4'd15, 1'b1, 24'hFFFFFF);
        send_item(REQ_READ, 20'hFFFFF, 8'h00, '0, 1'b0, '0);
        send_item(REQ_READ, 20'h00000, 8'h00, '0, 1'b0, '0);
        send_item(REQ_READ, 20'h00001, 8'h00, '0, 1'b0, '0);
        send_item(REQ_READ, 20'h00002, 8'h00, '0, 1'b0, '0);
        send_item(REQ_READ, 20'h00003, 8'h00, '0, 1'b0, '0);
        settle();

        // Random phases, each under a different section base.
        write_base(20'hFFFFF);
        random_run(150);
        settle();
        write_base(20'($urandom));
        random_run(150);
        settle();
        write_base(20'h00000);
        random_run(100);
        settle();
        write_base(20'($urandom));
        random_run(150);
        settle();

        // Closing stretch with the command side never idling.
        gaps_on = 1'b0;
        write_base(20'($urandom));
        random_run(100);
        settle();
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
